// ===== hdl/drmt_pkg.sv =====
// ----------------------------------------------------------------------------
// drmt_pkg - shared types and constants of the drag run milestone timer
// Holds the fixed-point widths, the mark and band thresholds for both unit
// modes, the event codes and the job record passed from front to back.
// ----------------------------------------------------------------------------
`default_nettype none

package drmt_pkg;

  // Distance accumulator width (valid range 32..48)
  localparam int ACC_W   = 40;
  localparam int TIME_W  = 32;
  localparam int SPEED_W = 16;
  localparam int PROD_W  = TIME_W + SPEED_W;
  localparam int SUM_W   = ((ACC_W > PROD_W) ? ACC_W : PROD_W) + 1;
  localparam int EV_W    = 3;
  localparam int NUM_EV  = 8;
  localparam int NUM_MARKS = 5;
  localparam int NUM_BANDS = 3;

  // Queue between front and back
  localparam int FIFO_DEPTH = 4;
  localparam int PTR_W      = $clog2(FIFO_DEPTH);

  // Command codes
  localparam logic CMD_SAMPLE = 1'b0;
  localparam logic CMD_START  = 1'b1;

  // Unit modes
  localparam logic MODE_METRIC   = 1'b0;
  localparam logic MODE_IMPERIAL = 1'b1;

  // Event codes
  localparam logic [EV_W-1:0] EV_60FT    = 3'd0;
  localparam logic [EV_W-1:0] EV_330FT   = 3'd1;
  localparam logic [EV_W-1:0] EV_EIGHTH  = 3'd2;
  localparam logic [EV_W-1:0] EV_QUARTER = 3'd3;
  localparam logic [EV_W-1:0] EV_1000FT  = 3'd4;
  localparam logic [EV_W-1:0] EV_BAND0   = 3'd5;
  localparam logic [EV_W-1:0] EV_BAND1   = 3'd6;
  localparam logic [EV_W-1:0] EV_BAND2   = 3'd7;

  // Distance marks; one count is 1/360000000 km or mile
  localparam logic [31:0] MARK_METRIC [NUM_MARKS] =
    '{32'd6583544, 32'd36209488, 32'd72420480, 32'd144840960, 32'd109728000};
  localparam logic [31:0] MARK_IMPERIAL [NUM_MARKS] =
    '{32'd4090911, 32'd22500000, 32'd45000000, 32'd90000000, 32'd68181819};

  // Speed band thresholds in hundredths
  localparam logic [SPEED_W-1:0] BAND_METRIC [NUM_BANDS] =
    '{16'd10000, 16'd20000, 16'd30000};
  localparam logic [SPEED_W-1:0] BAND_IMPERIAL [NUM_BANDS] =
    '{16'd6000, 16'd12000, 16'd18000};

  // One sample's worth of events, queued for the back end
  typedef struct packed {
    logic [NUM_EV-1:0]  fire;
    logic [TIME_W-1:0]  elapsed;
    logic [SPEED_W-1:0] speed;
    logic [TIME_W-1:0]  band1_time;
    logic [TIME_W-1:0]  band2_time;
  } job_t;

endpackage

`default_nettype wire

// ===== hdl/drmt_front.sv =====
// ----------------------------------------------------------------------------
// drmt_front - sample intake and milestone classification
// Stage 0 takes a transaction, computes the interval product and the speed
// band hits. Stage 1 accumulates distance, tests the marks and queues a job.
// ----------------------------------------------------------------------------
`default_nettype none

module drmt_front (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        unit_mode,
  input  wire logic                        in_tvalid,
  output logic                             in_tready,
  input  wire logic                        in_command,
  input  wire logic [drmt_pkg::TIME_W-1:0] in_elapsed,
  input  wire logic [drmt_pkg::SPEED_W-1:0] in_speed,
  output logic                             push,
  output drmt_pkg::job_t                   push_job,
  input  wire logic                        q_full
);
  import drmt_pkg::*;

  // Stage 0 state
  logic                 armed_r;
  logic [TIME_W-1:0]    prev_r;
  logic [NUM_BANDS-1:0] band_done_r;
  logic [TIME_W-1:0]    first_band_r;
  logic [TIME_W-1:0]    second_band_r;

  // Stage 1 registers
  logic                 s1_valid_r;
  logic                 s1_start_r;
  logic [PROD_W-1:0]    s1_prod_r;
  logic [TIME_W-1:0]    s1_elapsed_r;
  logic [SPEED_W-1:0]   s1_speed_r;
  logic [NUM_BANDS-1:0] s1_band_r;
  logic [TIME_W-1:0]    s1_t1_r;
  logic [TIME_W-1:0]    s1_t2_r;

  // Stage 1 state
  logic [ACC_W-1:0]     acc_r;
  logic [NUM_MARKS-1:0] mark_done_r;

  logic                 accept;
  logic                 s1_load;
  logic                 s1_fire;
  logic                 need_push;
  logic [TIME_W-1:0]    dt;
  logic [NUM_BANDS-1:0] band_hit;
  logic [TIME_W-1:0]    first_eff;
  logic [TIME_W-1:0]    t1;
  logic [TIME_W-1:0]    second_eff;
  logic [TIME_W-1:0]    t2;
  logic [SUM_W-1:0]     sum;
  logic [ACC_W-1:0]     acc_sat;
  logic [NUM_MARKS-1:0] mark_hit;

  // Handshake and stage advance
  assign need_push = !s1_start_r && ((|mark_hit) || (|s1_band_r));
  assign s1_fire   = s1_valid_r && (!need_push || !q_full);
  assign push      = s1_valid_r && need_push && !q_full;
  assign in_tready = !s1_valid_r || s1_fire;
  assign accept    = in_tvalid && in_tready;
  assign s1_load   = accept && ((in_command == CMD_START) || armed_r);

  // Interval and speed band tests
  always_comb begin
    dt = (in_elapsed >= prev_r) ? (in_elapsed - prev_r) : '0;
    for (int i = 0; i < NUM_BANDS; i++) begin
      band_hit[i] = !band_done_r[i] &&
                    (in_speed >= ((unit_mode == MODE_IMPERIAL) ?
                                  BAND_IMPERIAL[i] : BAND_METRIC[i]));
    end
    first_eff  = band_hit[0] ? in_elapsed : first_band_r;
    t1         = in_elapsed - first_eff;
    second_eff = band_hit[1] ? t1 : second_band_r;
    t2         = in_elapsed - first_eff - second_eff;
  end

  // Stage 0 run state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      armed_r       <= 1'b0;
      prev_r        <= '0;
      band_done_r   <= '0;
      first_band_r  <= '0;
      second_band_r <= '0;
    end else if (accept) begin
      if (in_command == CMD_START) begin
        armed_r       <= 1'b1;
        prev_r        <= '0;
        band_done_r   <= '0;
        first_band_r  <= '0;
        second_band_r <= '0;
      end else if (armed_r) begin
        prev_r        <= in_elapsed;
        band_done_r   <= band_done_r | band_hit;
        first_band_r  <= first_eff;
        second_band_r <= second_eff;
      end
    end
  end

  // Stage 1 valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (s1_load) begin
      s1_valid_r <= 1'b1;
    end else if (s1_fire) begin
      s1_valid_r <= 1'b0;
    end
  end

  // Stage 1 payload
  always_ff @(posedge clk) begin
    if (s1_load) begin
      s1_start_r   <= (in_command == CMD_START);
      s1_prod_r    <= dt * in_speed;
      s1_elapsed_r <= in_elapsed;
      s1_speed_r   <= in_speed;
      s1_band_r    <= band_hit;
      s1_t1_r      <= t1;
      s1_t2_r      <= t2;
    end
  end

  // Accumulate, saturate and test the marks
  always_comb begin
    sum     = SUM_W'(acc_r) + SUM_W'(s1_prod_r);
    acc_sat = (|sum[SUM_W-1:ACC_W]) ? {ACC_W{1'b1}} : sum[ACC_W-1:0];
    for (int i = 0; i < NUM_MARKS; i++) begin
      mark_hit[i] = !mark_done_r[i] &&
                    (sum >= SUM_W'((unit_mode == MODE_IMPERIAL) ?
                                   MARK_IMPERIAL[i] : MARK_METRIC[i]));
    end
  end

  // Stage 1 run state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r       <= '0;
      mark_done_r <= '0;
    end else if (s1_fire) begin
      if (s1_start_r) begin
        acc_r       <= '0;
        mark_done_r <= '0;
      end else begin
        acc_r       <= acc_sat;
        mark_done_r <= mark_done_r | mark_hit;
      end
    end
  end

  // Job record for the back end
  always_comb begin
    push_job.fire       = {s1_band_r, mark_hit};
    push_job.elapsed    = s1_elapsed_r;
    push_job.speed      = s1_speed_r;
    push_job.band1_time = s1_t1_r;
    push_job.band2_time = s1_t2_r;
  end

endmodule

`default_nettype wire

// ===== hdl/drmt_fifo.sv =====
// ----------------------------------------------------------------------------
// drmt_fifo - short job queue between front and back
// Decouples classification from event drain so either side can stall.
// ----------------------------------------------------------------------------
`default_nettype none

module drmt_fifo (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  input  wire drmt_pkg::job_t wr_job,
  output logic                full,
  input  wire logic           pop,
  output drmt_pkg::job_t      rd_job,
  output logic                empty
);
  import drmt_pkg::*;

  job_t             mem_r [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [PTR_W:0]   count_r;

  assign full   = (count_r == (PTR_W+1)'(FIFO_DEPTH));
  assign empty  = (count_r == '0);
  assign rd_job = mem_r[rd_ptr_r];

  // Store entry
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_job;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== hdl/drmt_back.sv =====
// ----------------------------------------------------------------------------
// drmt_back - event drain
// Takes one job at a time and emits its events in ascending code order,
// one per cycle through an output register, unless out_tready stalls it.
// ----------------------------------------------------------------------------
`default_nettype none

module drmt_back (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire drmt_pkg::job_t               rd_job,
  input  wire logic                         q_empty,
  output logic                              pop,
  output logic                              out_tvalid,
  input  wire logic                         out_tready,
  output logic [drmt_pkg::EV_W-1:0]         out_event,
  output logic [drmt_pkg::TIME_W-1:0]       out_time,
  output logic [drmt_pkg::SPEED_W-1:0]      out_speed,
  output logic                              out_last
);
  import drmt_pkg::*;

  // Current job
  logic                cur_valid_r;
  logic [NUM_EV-1:0]   cur_fire_r;
  logic [TIME_W-1:0]   cur_elapsed_r;
  logic [SPEED_W-1:0]  cur_speed_r;
  logic [TIME_W-1:0]   cur_t1_r;
  logic [TIME_W-1:0]   cur_t2_r;

  // Output register
  logic                out_valid_r;
  logic [EV_W-1:0]     out_event_r;
  logic [TIME_W-1:0]   out_time_r;
  logic [SPEED_W-1:0]  out_speed_r;
  logic                out_last_r;

  logic                out_free;
  logic                emit;
  logic                load;
  logic [EV_W-1:0]     sel;
  logic [NUM_EV-1:0]   remain;
  logic                sel_last;
  logic [TIME_W-1:0]   sel_time;

  // Pick the lowest pending event
  always_comb begin
    sel = '0;
    for (int i = NUM_EV - 1; i >= 0; i--) begin
      if (cur_fire_r[i]) begin
        sel = EV_W'(i);
      end
    end
    remain   = cur_fire_r & ~(NUM_EV'(1) << sel);
    sel_last = (remain == '0);
    case (sel)
      EV_BAND1: sel_time = cur_t1_r;
      EV_BAND2: sel_time = cur_t2_r;
      default:  sel_time = cur_elapsed_r;
    endcase
  end

  assign out_free = !out_valid_r || out_tready;
  assign emit     = cur_valid_r && out_free;
  assign load     = !cur_valid_r || (emit && sel_last);
  assign pop      = load && !q_empty;

  // Hold or refill the current job
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_valid_r <= 1'b0;
    end else if (load) begin
      cur_valid_r <= !q_empty;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur_fire_r    <= rd_job.fire;
      cur_elapsed_r <= rd_job.elapsed;
      cur_speed_r   <= rd_job.speed;
      cur_t1_r      <= rd_job.band1_time;
      cur_t2_r      <= rd_job.band2_time;
    end else if (emit) begin
      cur_fire_r    <= remain;
    end
  end

  // Output register valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Output register payload
  always_ff @(posedge clk) begin
    if (emit) begin
      out_event_r <= sel;
      out_time_r  <= sel_time;
      out_speed_r <= cur_speed_r;
      out_last_r  <= sel_last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_event  = out_event_r;
  assign out_time   = out_time_r;
  assign out_speed  = out_speed_r;
  assign out_last   = out_last_r;

endmodule

`default_nettype wire

// ===== hdl/drag_run_milestone_timer.sv =====
// ----------------------------------------------------------------------------
// drag_run_milestone_timer - drag strip run timer top level
// Integrates distance from speed samples and reports distance marks and
// speed band times as a stream of events.
// ----------------------------------------------------------------------------
// Usage:
//   in_* carries commands and samples: tuser = 1 starts a new run (arms the
//   timer and clears all milestones), tuser = 0 is a speed sample. Samples
//   before the first start are dropped.
//   out_* carries events, lowest code first; tlast marks the final event
//   caused by one sample. A sample that reaches nothing gives no event.
//   cfg_* writes unit_mode (0 metric, 1 imperial); write it only when idle.
// Timing:
//   One transaction is accepted per cycle while in_tready is high. A sample's
//   events pass from the mark stage register through the job queue and the
//   drain register into the output register. Events drain one per cycle
//   while out_tready is high; the four-entry job queue absorbs bursts before
//   the intake stalls.
// Reset: rst_n (synchronous) disarms the timer, clears run state, the queue
//   and the output register, and selects metric mode.
// Stall: while out_tready is low the event holds, the queue fills and then
//   in_tready drops; no event is lost.
// ----------------------------------------------------------------------------
`default_nettype none

module drag_run_milestone_timer (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // Configuration
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic        cfg_data,      // unit_mode
  // Input stream
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [47:0] in_tdata,      // [31:0] elapsed_ms, [47:32] speed
  input  wire logic        in_tuser,      // command
  // Result stream
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [55:0]      out_tdata,     // [2:0] event_res, [34:3] time_ms,
                                          // [50:35] speed_at, [55:51] zero
  output logic             out_tlast      // last
);
  import drmt_pkg::*;

  logic                unit_mode_r;
  logic                push;
  job_t                push_job;
  logic                q_full;
  logic                pop;
  job_t                rd_job;
  logic                q_empty;
  logic [EV_W-1:0]     out_event;
  logic [TIME_W-1:0]   out_time;
  logic [SPEED_W-1:0]  out_speed;

  // Unit mode register
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      unit_mode_r <= MODE_METRIC;
    end else if (cfg_valid && cfg_ready) begin
      unit_mode_r <= cfg_data;
    end
  end

  drmt_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .unit_mode  (unit_mode_r),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_command (in_tuser),
    .in_elapsed (in_tdata[31:0]),
    .in_speed   (in_tdata[47:32]),
    .push       (push),
    .push_job   (push_job),
    .q_full     (q_full)
  );

  drmt_fifo u_fifo (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (push),
    .wr_job (push_job),
    .full   (q_full),
    .pop    (pop),
    .rd_job (rd_job),
    .empty  (q_empty)
  );

  drmt_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .rd_job     (rd_job),
    .q_empty    (q_empty),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_event  (out_event),
    .out_time   (out_time),
    .out_speed  (out_speed),
    .out_last   (out_tlast)
  );

  // Pack the result fields
  assign out_tdata = {5'b0, out_speed, out_time, out_event};

endmodule

`default_nettype wire

// ===== hdl/drmt_monitor.sv =====
// ----------------------------------------------------------------------------
// drmt_monitor - port-level assertions for the drag run milestone timer
// Watches the result stream for ordering and framing of event transactions.
// ----------------------------------------------------------------------------
`default_nettype none

module drmt_monitor (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        out_tvalid,
  input  wire logic        out_tready,
  input  wire logic [55:0] out_tdata,
  input  wire logic        out_tlast
);
  import drmt_pkg::*;

  // Hold a stalled event
  a_valid_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> out_tvalid)
    else $error("out_tvalid dropped while stalled");

  a_data_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> ($stable(out_tdata) && $stable(out_tlast)))
    else $error("event changed while stalled");

  // Events of one sample follow back to back in rising code order
  a_code_order: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tready && !out_tlast) |=>
      (out_tvalid && (out_tdata[2:0] > $past(out_tdata[2:0]))))
    else $error("event order broken within a sample");

  // Highest code always closes its sample
  a_top_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (out_tdata[2:0] == EV_BAND2)) |-> out_tlast)
    else $error("last band event without tlast");

endmodule

bind drag_run_milestone_timer drmt_monitor u_drmt_monitor (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);

`default_nettype wire

// ===== tb/sv/drag_run_milestone_timer_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// drag_run_milestone_timer_tb - self-checking bench for the drag run timer
// Drives start commands and speed samples into the input stream and predicts
// every distance mark and speed band event in both unit modes. Each event on
// the output stream is checked field by field against the oldest prediction.
// Both stream sides idle in random bursts, and the receiver also holds off
// for one long stretch so that the input stalls.
// ----------------------------------------------------------------------------

module drag_run_milestone_timer_tb;

  import drmt_pkg::*;

  localparam int RANDOM_ITEMS   = 300;
  localparam int SETTLE_CYCLES  = 16;
  localparam int RX_HOLD_CYCLES = 300;
  localparam int FILL_RUNS      = 8;
  localparam int DRAIN_LIMIT    = 20000;
  localparam int RUN_LIMIT_NS   = 5_000_000;

  // Mark thresholds in 1/360000000 km or mile, rounded up
  localparam logic [31:0] KM_MARKS [NUM_MARKS] =
    '{32'd6583544, 32'd36209488, 32'd72420480, 32'd144840960, 32'd109728000};
  localparam logic [31:0] MI_MARKS [NUM_MARKS] =
    '{32'd4090911, 32'd22500000, 32'd45000000, 32'd90000000, 32'd68181819};
  // Band thresholds in hundredths of km/h or mph
  localparam logic [SPEED_W-1:0] KMH_BANDS [NUM_BANDS] = '{16'd10000, 16'd20000, 16'd30000};
  localparam logic [SPEED_W-1:0] MPH_BANDS [NUM_BANDS] = '{16'd6000, 16'd12000, 16'd18000};
  localparam logic [ACC_W-1:0]   ACC_FULL = {ACC_W{1'b1}};

  typedef struct packed {
    logic [EV_W-1:0]    code;
    logic [TIME_W-1:0]  time_ms;
    logic [SPEED_W-1:0] speed_at;
    logic               last;
  } milestone_t;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        cfg_valid  = 1'b0;
  logic        cfg_ready;
  logic        cfg_data   = MODE_METRIC;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [47:0] in_tdata   = '0;   // [31:0] elapsed_ms, [47:32] speed
  logic        in_tuser   = CMD_SAMPLE;  // command
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [55:0] out_tdata;         // [2:0] event_res, [34:3] time_ms, [50:35] speed_at
  logic        out_tlast;         // last

  // Predicted run state
  logic               unit_sel      = MODE_METRIC;
  logic               run_armed     = 1'b0;
  logic [TIME_W-1:0]  last_elapsed  = '0;
  logic [ACC_W-1:0]   distance_cnt  = '0;
  logic [NUM_EV-1:0]  done_mask     = '0;
  logic [TIME_W-1:0]  band0_mark_ms = '0;
  logic [TIME_W-1:0]  band1_span_ms = '0;

  milestone_t pending_events [$];
  int         error_count = 0;
  int         items_sent  = 0;
  bit         idle_en     = 1'b1;
  bit         rx_hold_req = 1'b0;

  drag_run_milestone_timer dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin : watchdog
    #(RUN_LIMIT_NS);
    $display("Simulation FAILED");
    $finish;
  end

  // Advance the run state by one transaction and queue the events it causes
  task automatic predict_milestones(input logic cmd, input logic [TIME_W-1:0] el,
                                    input logic [SPEED_W-1:0] spd);
    logic [TIME_W-1:0]  dt;
    logic [63:0]        sum;
    logic [31:0]        mark;
    logic [NUM_EV-1:0]  fire;
    logic [TIME_W-1:0]  ev_ms [NUM_EV];
    logic [SPEED_W-1:0] band_lo, band_mid, band_hi;
    int                 final_code;
    milestone_t         ev;
    if (cmd == CMD_START) begin
      run_armed     = 1'b1;
      last_elapsed  = '0;
      distance_cnt  = '0;
      done_mask     = '0;
      band0_mark_ms = '0;
      band1_span_ms = '0;
    end else if (run_armed) begin
      dt           = (el >= last_elapsed) ? el - last_elapsed : '0;
      last_elapsed = el;
      sum          = 64'(distance_cnt) + 64'(dt) * 64'(spd);
      distance_cnt = (sum > 64'(ACC_FULL)) ? ACC_FULL : sum[ACC_W-1:0];
      fire = '0;
      for (int i = 0; i < NUM_EV; i++) ev_ms[i] = '0;
      // Check distance marks against the current mode
      for (int i = 0; i < NUM_MARKS; i++) begin
        mark = (unit_sel == MODE_IMPERIAL) ? MI_MARKS[i] : KM_MARKS[i];
        if (!done_mask[i] && 64'(distance_cnt) >= 64'(mark)) begin
          fire[i]  = 1'b1;
          ev_ms[i] = el;
        end
      end
      // Speed bands; each duration builds on the earlier band times
      band_lo  = (unit_sel == MODE_IMPERIAL) ? MPH_BANDS[0] : KMH_BANDS[0];
      band_mid = (unit_sel == MODE_IMPERIAL) ? MPH_BANDS[1] : KMH_BANDS[1];
      band_hi  = (unit_sel == MODE_IMPERIAL) ? MPH_BANDS[2] : KMH_BANDS[2];
      if (!done_mask[EV_BAND0] && spd >= band_lo) begin
        fire[EV_BAND0]  = 1'b1;
        band0_mark_ms   = el;
        ev_ms[EV_BAND0] = el;
      end
      if (!done_mask[EV_BAND1] && spd >= band_mid) begin
        fire[EV_BAND1]  = 1'b1;
        band1_span_ms   = el - band0_mark_ms;
        ev_ms[EV_BAND1] = band1_span_ms;
      end
      if (!done_mask[EV_BAND2] && spd >= band_hi) begin
        fire[EV_BAND2]  = 1'b1;
        ev_ms[EV_BAND2] = el - band0_mark_ms - band1_span_ms;
      end
      done_mask  = done_mask | fire;
      final_code = -1;
      for (int i = 0; i < NUM_EV; i++) if (fire[i]) final_code = i;
      for (int i = 0; i < NUM_EV; i++) begin
        if (fire[i]) begin
          ev.code     = EV_W'(i);
          ev.time_ms  = ev_ms[i];
          ev.speed_at = spd;
          ev.last     = (i == final_code);
          pending_events.push_back(ev);
        end
      end
    end
  endtask

  // Offer one transaction, hold it until accepted, then predict
  task automatic send_item(input logic cmd, input logic [TIME_W-1:0] el,
                           input logic [SPEED_W-1:0] spd);
    if (idle_en && $urandom_range(0, 4) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= {spd, el};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict_milestones(cmd, el, spd);
    items_sent++;
  endtask

  // Drop the input and wait until every predicted event has arrived
  task automatic wait_for_drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_events.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_unit_mode(input logic mode);
    wait_for_drain();
    cfg_valid <= 1'b1;
    cfg_data  <= mode;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    unit_sel = mode;
  endtask

  // One run: a start, then mostly rising time and speed with some noise
  task automatic drive_random_run(input int n_samples);
    logic [TIME_W-1:0]  el;
    logic [SPEED_W-1:0] spd;
    int                 pick;
    el  = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 500);
    spd = SPEED_W'($urandom_range(0, 3000));
    send_item(CMD_START, $urandom, SPEED_W'($urandom));
    for (int k = 0; k < n_samples; k++) begin
      pick = $urandom_range(0, 24);
      if (pick == 0) begin
        el  = $urandom;
        spd = SPEED_W'($urandom);
      end else if (pick == 1) begin
        el = el - TIME_W'($urandom_range(1, 2000));
      end else if (pick == 2) begin
        spd = SPEED_W'($urandom_range(0, 65535));
      end else if (pick == 3) begin
        send_item(CMD_START, $urandom, SPEED_W'($urandom));
        el  = $urandom_range(0, 500);
        spd = SPEED_W'($urandom_range(0, 3000));
      end else begin
        el  = el + TIME_W'($urandom_range(5, 1500));
        spd = (spd > 16'd61000) ? 16'hFFFF : spd + SPEED_W'($urandom_range(0, 4500));
      end
      send_item(CMD_SAMPLE, el, spd);
    end
  endtask

  task automatic test_unarmed_samples();
    send_item(CMD_SAMPLE, 32'hFFFF_FFFF, 16'hFFFF);
    send_item(CMD_SAMPLE, 32'd1000, 16'd30000);
    wait_for_drain();
  endtask

  task automatic test_metric_run();
    write_unit_mode(MODE_METRIC);
    // Start fields carry junk that must be ignored
    send_item(CMD_START, 32'hDEAD_BEEF, 16'hFFFF);
    send_item(CMD_SAMPLE, 32'd1000, 16'd10000);
    send_item(CMD_SAMPLE, 32'd2000, 16'd20000);
    send_item(CMD_SAMPLE, 32'd3000, 16'd30000);
    send_item(CMD_SAMPLE, 32'd2500, 16'd100);
    send_item(CMD_SAMPLE, 32'd6000, 16'd30000);
    send_item(CMD_SAMPLE, 32'd7000, 16'hFFFF);
    wait_for_drain();
  endtask

  task automatic test_unit_switch_mid_run();
    send_item(CMD_START, 32'd0, 16'd0);
    send_item(CMD_SAMPLE, 32'd500, 16'd6000);
    write_unit_mode(MODE_IMPERIAL);
    send_item(CMD_SAMPLE, 32'd1000, 16'd6000);
    // Time runs backwards: no distance, band duration wraps
    send_item(CMD_SAMPLE, 32'd100, 16'd12000);
    send_item(CMD_SAMPLE, 32'd200, 16'd18000);
    send_item(CMD_SAMPLE, 32'hFFFF_FFFF, 16'hFFFF);
    wait_for_drain();
  endtask

  task automatic test_saturation();
    send_item(CMD_START, 32'hFFFF_FFFF, 16'h0000);
    send_item(CMD_SAMPLE, 32'h0000_0000, 16'h0000);
    send_item(CMD_SAMPLE, 32'hFFFF_FFFF, 16'hFFFF);
    send_item(CMD_SAMPLE, 32'hFFFF_FFFF, 16'hFFFF);
    write_unit_mode(MODE_METRIC);
    send_item(CMD_START, 32'd0, 16'd0);
    send_item(CMD_SAMPLE, 32'hFFFF_FFFF, 16'hFFFF);
    wait_for_drain();
  endtask

  task automatic test_output_backpressure();
    rx_hold_req = 1'b1;
    // Short runs that each fire several events, enough to fill the queue
    for (int k = 0; k < FILL_RUNS; k++) begin
      send_item(CMD_START, 32'd0, 16'd0);
      send_item(CMD_SAMPLE, 32'd1000, 16'd30000);
    end
    drive_random_run(40);
    wait_for_drain();
  endtask

  task automatic test_sender_pause();
    send_item(CMD_START, 32'd0, 16'd0);
    send_item(CMD_SAMPLE, 32'd800, 16'd9000);
    send_item(CMD_SAMPLE, 32'd1600, 16'd15000);
    wait_for_drain();
    send_item(CMD_SAMPLE, 32'd2400, 16'd21000);
    send_item(CMD_SAMPLE, 32'd4000, 16'd31000);
    wait_for_drain();
  endtask

  task automatic test_random_runs();
    int first_item;
    first_item = items_sent;
    while (items_sent - first_item < RANDOM_ITEMS) begin
      if ($urandom_range(0, 2) == 0) write_unit_mode(1'($urandom_range(0, 1)));
      idle_en = ($urandom_range(0, 3) != 0);
      drive_random_run($urandom_range(3, 24));
    end
    idle_en = 1'b1;
    wait_for_drain();
  endtask

  task automatic test_quiet_finish();
    idle_en = 1'b0;
    write_unit_mode(MODE_IMPERIAL);
    drive_random_run(16);
    write_unit_mode(MODE_METRIC);
    drive_random_run(16);
    in_tvalid <= 1'b0;
  endtask

  // Receiver: random holds, plus one long hold when requested
  initial begin : result_receiver
    int burst_left;
    int hold_left;
    burst_left = 0;
    hold_left  = 0;
    forever begin
      @(posedge clk);
      if (rx_hold_req) begin
        hold_left   = RX_HOLD_CYCLES;
        rx_hold_req = 1'b0;
      end
      if (hold_left > 0) begin
        out_tready <= 1'b0;
        hold_left--;
      end else if (burst_left > 0) begin
        out_tready <= 1'b0;
        burst_left--;
      end else if (idle_en && $urandom_range(0, 5) == 0) begin
        out_tready <= 1'b0;
        burst_left = $urandom_range(0, 6);
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      error_count++;
    end
  endtask

  // Compare each accepted event with the oldest prediction
  always @(posedge clk) begin : event_checker
    milestone_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_events.size() == 0) begin
        $display("%0t: event with none expected, expected none, actual code %0d time %0d",
                 $time, out_tdata[2:0], out_tdata[34:3]);
        error_count++;
      end else begin
        want = pending_events.pop_front();
        check_field("event_res", 64'(want.code), 64'(out_tdata[2:0]));
        check_field("time_ms", 64'(want.time_ms), 64'(out_tdata[34:3]));
        check_field("speed_at", 64'(want.speed_at), 64'(out_tdata[50:35]));
        check_field("padding", 64'd0, 64'(out_tdata[55:51]));
        check_field("last", 64'(want.last), 64'(out_tlast));
      end
    end
  end

  initial begin : test_sequence
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    test_unarmed_samples();
    test_metric_run();
    test_unit_switch_mid_run();
    test_saturation();
    test_output_backpressure();
    test_sender_pause();
    test_random_runs();
    test_quiet_finish();
    // Let the last events drain, bounded
    @(posedge clk);
    for (int w = 0; w < DRAIN_LIMIT && pending_events.size() != 0; w++) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (pending_events.size() != 0) begin
      $display("%0t: events missing, expected %0d more, actual 0", $time,
               pending_events.size());
      error_count++;
    end
    if (error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== drag_run_milestone_timer.f =====
hdl/drmt_pkg.sv
hdl/drmt_front.sv
hdl/drmt_fifo.sv
hdl/drmt_back.sv
hdl/drag_run_milestone_timer.sv
hdl/drmt_monitor.sv
tb/sv/drag_run_milestone_timer_tb.sv
